// File: rtl/nvbs_pkg.sv
// ----------------------------------------------------------------------------
// nvbs_pkg
// Shared types and codes for the nearest-value binary search block.
// ----------------------------------------------------------------------------
package nvbs_pkg;

	localparam int DATA_W   = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// Command codes
	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FOUND    = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Search sequencer states
	typedef enum logic {
		SRCH_IDLE = 1'b0,
		SRCH_RUN  = 1'b1
	} srch_state_t;

	// Launch request from command decode to the sequencer
	typedef struct packed {
		logic                     launch;
		logic signed [DATA_W-1:0] key;
	} srch_req_t;

	// Finished search from the sequencer
	typedef struct packed {
		logic                     done;
		logic                     busy;
		logic signed [DATA_W-1:0] value;
	} srch_rsp_t;

	localparam logic signed [DATA_W-1:0] VALUE_NONE = '1;
	localparam logic signed [DATA_W-1:0] VALUE_ZERO = '0;

endpackage

// File: rtl/nvbs_search.sv
// ----------------------------------------------------------------------------
// nvbs_search
// Binary search sequencer: walks midpoints over the table memory, one read
// per cycle, and keeps the closest value seen so far.
// ----------------------------------------------------------------------------
module nvbs_search #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  nvbs_pkg::srch_req_t                  req,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
	output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
	input  logic signed [nvbs_pkg::DATA_W-1:0]   rd_data,
	output nvbs_pkg::srch_rsp_t                  rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DW = nvbs_pkg::DATA_W;

	nvbs_pkg::srch_state_t state_q, state_n;

	logic [CW-1:0]           lo_q, hi1_q, mid_q;
	logic [CW-1:0]           lo_n, hi1_n, mid_n;
	logic [CW-1:0]           mid_up, mid_dn, mid_init;
	logic signed [DW-1:0]    key_q;
	logic signed [DW-1:0]    best_q, best_n;
	logic [DW:0]             best_d_q;
	logic                    have_q;
	logic                    hit, less, take, cont;
	logic signed [DW:0]      diff;
	logic [DW:0]             mag;

	// Compare the fetched midpoint against the key
	always_comb begin
		hit  = (rd_data == key_q);
		less = (rd_data < key_q);
		diff = {rd_data[DW-1], rd_data} - {key_q[DW-1], key_q};
		mag  = diff[DW] ? (DW+1)'(-diff) : diff;
		take = !have_q || (mag < best_d_q);
		best_n = take ? rd_data : best_q;
	end

	// Next midpoint for both outcomes, chosen by the compare
	always_comb begin
		mid_init = (count - CW'(1)) >> 1;
		mid_up   = mid_q + CW'(1) + ((hi1_q - mid_q - CW'(2)) >> 1);
		mid_dn   = lo_q + ((mid_q - lo_q - CW'(1)) >> 1);
		if (less) begin
			lo_n  = mid_q + CW'(1);
			hi1_n = hi1_q;
			mid_n = mid_up;
			cont  = !hit && ((mid_q + CW'(1)) < hi1_q);
		end else begin
			lo_n  = lo_q;
			hi1_n = mid_q;
			mid_n = mid_dn;
			cont  = !hit && (lo_q < mid_q);
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nvbs_pkg::SRCH_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state, read address and finish strobe
	always_comb begin
		state_n   = state_q;
		rd_addr   = mid_init[AW-1:0];
		rsp.done  = 1'b0;
		rsp.busy  = 1'b0;
		rsp.value = hit ? rd_data : best_n;
		unique case (state_q)
			nvbs_pkg::SRCH_IDLE: begin
				if (req.launch) begin
					state_n = nvbs_pkg::SRCH_RUN;
				end
			end
			nvbs_pkg::SRCH_RUN: begin
				rsp.busy = 1'b1;
				rd_addr  = mid_n[AW-1:0];
				if (!cont) begin
					rsp.done = 1'b1;
					state_n  = nvbs_pkg::SRCH_IDLE;
				end
			end
			default: begin
				state_n = nvbs_pkg::SRCH_IDLE;
			end
		endcase
	end

	// Search window and best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (state_q == nvbs_pkg::SRCH_IDLE) begin
			if (req.launch) begin
				have_q <= 1'b0;
			end
		end else begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nvbs_pkg::SRCH_IDLE) begin
			lo_q  <= '0;
			hi1_q <= count;
			mid_q <= mid_init;
			key_q <= req.key;
		end else begin
			lo_q  <= lo_n;
			hi1_q <= hi1_n;
			mid_q <= mid_n;
			if (take) begin
				best_q   <= rd_data;
				best_d_q <= mag;
			end
		end
	end

endmodule

// File: rtl/nearest_value_binary_search.sv
// ----------------------------------------------------------------------------
// nearest_value_binary_search
// Sorted table of signed values with clear, append and nearest-value query.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                Payload
// command   in         start, transfer when !busy  opcode, operand_value
// result    out        done strobe, one cycle    status, nearest_value
//
// Clear, append and unused opcodes strobe their result in the next cycle and
// busy stays low, so commands may follow back to back.
// A query on n entries holds busy while it searches, one table memory read per
// cycle, and strobes its result in the cycle busy falls.
// Reset empties the table (entry count to zero); table contents need no clear.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module nearest_value_binary_search #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [nvbs_pkg::OP_W-1:0]          opcode,
	input  logic signed [nvbs_pkg::DATA_W-1:0] operand_value,
	output logic                               done,
	output logic [nvbs_pkg::STATUS_W-1:0]      status,
	output logic signed [nvbs_pkg::DATA_W-1:0] nearest_value
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DW = nvbs_pkg::DATA_W;

	logic signed [DW-1:0]  table_mem [TABLE_DEPTH];
	logic signed [DW-1:0]  rd_data_q;
	logic [AW-1:0]         rd_addr;
	logic [CW-1:0]         entry_count_q;
	logic                  accept, full, empty, wr_en;
	nvbs_pkg::op_t         op;
	nvbs_pkg::srch_req_t   req;
	nvbs_pkg::srch_rsp_t   rsp;
	logic                  done_q;
	nvbs_pkg::status_t     status_q;
	logic signed [DW-1:0]  value_q;

	// Decode the command transfer
	always_comb begin
		accept     = start && !busy;
		op         = nvbs_pkg::op_t'(opcode);
		full       = (entry_count_q == CW'(TABLE_DEPTH));
		empty      = (entry_count_q == '0);
		wr_en      = accept && (op == nvbs_pkg::OP_APPEND) && !full;
		req.launch = accept && (op == nvbs_pkg::OP_QUERY) && !empty;
		req.key    = operand_value;
	end

	assign busy = rsp.busy;

	// Table memory: appends and searches never overlap, so no forwarding
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[entry_count_q[AW-1:0]] <= operand_value;
		end
		rd_data_q <= table_mem[rd_addr];
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (accept && op == nvbs_pkg::OP_CLEAR) begin
			entry_count_q <= '0;
		end else if (wr_en) begin
			entry_count_q <= entry_count_q + CW'(1);
		end
	end

	nvbs_search #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.count   (entry_count_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data_q),
		.rsp     (rsp)
	);

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp.done || (accept && !req.launch);
		end
	end

	// Result payload: a finished search wins over the command decode
	always_ff @(posedge clk) begin
		priority if (rsp.done) begin
			status_q <= nvbs_pkg::ST_FOUND;
			value_q  <= rsp.value;
		end else if (op == nvbs_pkg::OP_APPEND && full) begin
			status_q <= nvbs_pkg::ST_FULL;
			value_q  <= nvbs_pkg::VALUE_ZERO;
		end else if (op == nvbs_pkg::OP_QUERY && empty) begin
			status_q <= nvbs_pkg::ST_EMPTY;
			value_q  <= nvbs_pkg::VALUE_NONE;
		end else begin
			status_q <= nvbs_pkg::ST_ACCEPTED;
			value_q  <= nvbs_pkg::VALUE_ZERO;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign nearest_value = value_q;

	// No result strobes while a search is running
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe during search");

	// End of a search always delivers an answered query
	a_search_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && status == nvbs_pkg::ST_FOUND))
		else $error("search ended without answer");

	// Entry count never passes the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(TABLE_DEPTH))
		else $error("entry count overflow");

	// A query on an empty table answers at once, without a search
	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == nvbs_pkg::OP_QUERY && empty) |=>
			(done && !busy && status == nvbs_pkg::ST_EMPTY))
		else $error("empty-table query mishandled");

endmodule
